[hw/rtl/sbph_pkg.sv]
// spectrum bar peak hold: shared types, constants and helper functions
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps

package sbph_pkg;

    // peak store geometry
    localparam int unsigned COLUMNS = 128;
    localparam int unsigned IDX_W   = $clog2(COLUMNS);

    // configuration port
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STYLE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_SPEED    = 2'd2;

    // style mode codes
    localparam logic [1:0] STYLE_MIRROR = 2'd1;
    localparam logic [1:0] STYLE_WIDE   = 2'd2;

    // reset values of the registers
    localparam logic [1:0] STYLE_RESET   = STYLE_MIRROR;
    localparam logic [7:0] DIVISOR_RESET = 8'd4;
    localparam logic [3:0] FALL_RESET    = 4'd7;

    // screen rows and steps
    localparam logic [5:0] ROW_BOTTOM   = 6'd63;
    localparam logic [5:0] CLAMP_MIRROR = 6'd62;
    localparam logic [5:0] CLAMP_WIDE   = 6'd60;
    localparam logic [5:0] ROW_MID      = 6'd32;
    localparam logic [3:0] FALL_BASE    = 4'd10;
    localparam logic [3:0] FALL_MIRROR  = 4'd1;
    localparam logic [6:0] PEAK_RESET   = 7'd63;

    // mirrored x origins
    localparam logic [7:0] X_LEFT_BASE  = 8'd128;
    localparam logic [7:0] X_RIGHT_BASE = 8'd127;

    typedef struct packed {
        logic [6:0]  column;
        logic [15:0] magnitude;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] x_pos;
        logic [5:0] bar_top;
        logic [5:0] peak_top;
        logic       peak_shown;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] style_mode;
        logic [7:0] scale_divisor;
        logic [3:0] fall_speed;
    } t_cfg;

    // column with its bar top, out of the divider
    typedef struct packed {
        logic [6:0] column;
        logic [5:0] bar;
    } t_bar_item;

    // one or two draw beats caused by one input beat
    typedef struct packed {
        t_out_beat first;
        t_out_beat second;
        logic      two;
    } t_pair;

    typedef struct packed {
        logic [6:0] p_new;
        logic [5:0] top;
        logic       shown;
    } t_upd;

    // peak entry of a column
    function automatic logic [IDX_W-1:0] col_to_idx(input logic [6:0] col);
        return IDX_W'(32'(col) % COLUMNS);
    endfunction

    // one restoring division step for quotient bit k: {bit, remainder}
    function automatic logic [14:0] div_step(input logic [13:0] rem,
                                             input logic [7:0]  dv,
                                             input logic [2:0]  k);
        logic [13:0] shifted;
        shifted = 14'(dv) << k;
        if (rem >= shifted) begin
            return {1'b1, rem - shifted};
        end
        return {1'b0, rem};
    endfunction

    // one falling-dot update of a peak entry against a bar top
    function automatic t_upd peak_update(input logic [6:0] p,
                                         input logic [5:0] bar,
                                         input logic [5:0] clampv,
                                         input logic [3:0] step);
        t_upd       u;
        logic [6:0] pc;
        pc = p;
        if (p > {1'b0, bar}) begin
            u.p_new = {1'b0, bar};
            u.top   = '0;
            u.shown = 1'b0;
        end else begin
            if (p > {1'b0, clampv}) begin
                pc = {1'b0, clampv};
            end
            u.shown = 1'b1;
            u.top   = pc[5:0];
            u.p_new = pc + {3'b000, step};
        end
        return u;
    endfunction

endpackage

[hw/rtl/sbph_div.sv]
// spectrum bar peak hold: three-stage pipelined divider that turns the
// magnitude into a bar top row (quotient clamped to 63); uses sbph_pkg
`timescale 1ns / 1ps

module sbph_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sbph_pkg::t_in_beat    i_in_beat,
    input  sbph_pkg::t_cfg        i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sbph_pkg::t_bar_item   o_item
);
    import sbph_pkg::*;

    logic [7:0]  dv;
    logic        sat0;
    logic [14:0] st_a, st_b, st_c, st_d, st_e, st_f;
    logic [5:0]  q6;
    logic [5:0]  h;
    logic        s1_rdy, s2_rdy, s3_rdy;

    logic        r_s1_v, r_s2_v, r_s3_v;
    logic [6:0]  r_s1_col, r_s2_col, r_s3_col;
    logic        r_s1_sat, r_s2_sat;
    logic [13:0] r_s1_rem, r_s2_rem;
    logic [1:0]  r_s1_q;
    logic [3:0]  r_s2_q;
    logic [5:0]  r_s3_bar;

    // divisor zero acts as one
    assign dv = (i_cfg.scale_divisor == '0) ? 8'd1 : i_cfg.scale_divisor;

    // quotient of 64 or more saturates; otherwise six bits remain
    assign sat0 = i_in_beat.magnitude >= {2'b00, dv, 6'b000000};

    // two quotient bits per stage
    assign st_a = div_step(i_in_beat.magnitude[13:0], dv, 3'd5);
    assign st_b = div_step(st_a[13:0], dv, 3'd4);
    assign st_c = div_step(r_s1_rem, dv, 3'd3);
    assign st_d = div_step(st_c[13:0], dv, 3'd2);
    assign st_e = div_step(r_s2_rem, dv, 3'd1);
    assign st_f = div_step(st_e[13:0], dv, 3'd0);

    assign q6 = {r_s2_q, st_e[14], st_f[14]};
    assign h  = r_s2_sat ? ROW_BOTTOM : q6;

    // stage handshake, bubbles collapse
    assign s3_rdy  = !r_s3_v || i_ready;
    assign s2_rdy  = !r_s2_v || s3_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign o_ready = s1_rdy;
    assign o_valid = r_s3_v;
    assign o_item  = '{column: r_s3_col, bar: r_s3_bar};

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_v <= i_valid;
            if (s2_rdy) r_s2_v <= r_s1_v;
            if (s3_rdy) r_s3_v <= r_s2_v;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r_s1_col <= i_in_beat.column;
            r_s1_sat <= sat0;
            r_s1_rem <= st_b[13:0];
            r_s1_q   <= {st_a[14], st_b[14]};
        end
        if (s2_rdy && r_s1_v) begin
            r_s2_col <= r_s1_col;
            r_s2_sat <= r_s1_sat;
            r_s2_rem <= st_d[13:0];
            r_s2_q   <= {r_s1_q, st_c[14], st_d[14]};
        end
        if (s3_rdy && r_s2_v) begin
            r_s3_col <= r_s2_col;
            r_s3_bar <= ROW_BOTTOM - h;
        end
    end

endmodule

[hw/rtl/sbph_peak.sv]
// spectrum bar peak hold: peak row memory with registered read, valid bits,
// write forwarding and the falling-dot update stage; uses sbph_pkg
`timescale 1ns / 1ps

module sbph_peak (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sbph_pkg::t_bar_item   i_item,
    input  sbph_pkg::t_cfg        i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sbph_pkg::t_pair       o_pair
);
    import sbph_pkg::*;

    logic [6:0]       r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_vld;

    logic             r_v;
    logic [6:0]       r_col;
    logic [5:0]       r_bar;
    logic [6:0]       r_rd_data;
    logic             r_rd_vld;
    logic             r_fwd_v;
    logic [IDX_W-1:0] r_fwd_idx;
    logic [6:0]       r_fwd_data;

    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wb_idx;
    logic [6:0]       p_cur;
    logic [6:0]       p_final;
    logic             mirror;
    logic [3:0]       step;
    logic [5:0]       bar_w;
    t_upd             u1, u2, uw;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign rd_en   = i_valid && o_ready;
    assign wr_en   = r_v && i_ready;
    assign rd_idx  = col_to_idx(i_item.column);
    assign wb_idx  = col_to_idx(r_col);

    // memory port: read on entry, write back when the stage drains
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx];
            r_rd_vld  <= r_vld[rd_idx];
            r_col     <= i_item.column;
            r_bar     <= i_item.bar;
        end
        if (wr_en) begin
            r_mem[wb_idx] <= p_final;
        end
        if (wr_en) begin
            r_fwd_idx  <= wb_idx;
            r_fwd_data <= p_final;
        end
    end

    // control: stage valid, entry valid bits, forward valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_vld   <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            if (o_ready) r_v <= i_valid;
            if (wr_en) begin
                r_vld[wb_idx] <= 1'b1;
                r_fwd_v       <= 1'b1;
            end
        end
    end

    // current peak: last write wins, unwritten entries read as reset row
    always_comb begin
        if (r_fwd_v && r_fwd_idx == wb_idx) begin
            p_cur = r_fwd_data;
        end else if (r_rd_vld) begin
            p_cur = r_rd_data;
        end else begin
            p_cur = PEAK_RESET;
        end
    end

    // wide modes: fall step and bar limits
    always_comb begin
        step  = (i_cfg.fall_speed > FALL_BASE) ? 4'd0 : FALL_BASE - i_cfg.fall_speed;
        bar_w = r_bar;
        if (i_cfg.style_mode != STYLE_WIDE && bar_w < ROW_MID) begin
            bar_w = ROW_MID;
        end
        if (bar_w > CLAMP_WIDE) begin
            bar_w = CLAMP_WIDE;
        end
    end

    // mirrored mode updates the entry twice in a row
    assign mirror = (i_cfg.style_mode == STYLE_MIRROR);
    assign u1     = peak_update(p_cur, r_bar, CLAMP_MIRROR, FALL_MIRROR);
    assign u2     = peak_update(u1.p_new, r_bar, CLAMP_MIRROR, FALL_MIRROR);
    assign uw     = peak_update(p_cur, bar_w, CLAMP_WIDE, step);
    assign p_final = mirror ? u2.p_new : uw.p_new;

    // draw beats
    always_comb begin
        o_pair = '0;
        if (mirror) begin
            o_pair.two               = 1'b1;
            o_pair.first.x_pos       = X_LEFT_BASE - {1'b0, r_col};
            o_pair.first.bar_top     = r_bar;
            o_pair.first.peak_top    = u1.top;
            o_pair.first.peak_shown  = u1.shown;
            o_pair.first.last        = 1'b0;
            o_pair.second.x_pos      = X_RIGHT_BASE + {1'b0, r_col};
            o_pair.second.bar_top    = r_bar;
            o_pair.second.peak_top   = u2.top;
            o_pair.second.peak_shown = u2.shown;
            o_pair.second.last       = 1'b1;
        end else begin
            o_pair.two               = 1'b0;
            o_pair.first.x_pos       = {r_col[5:0], 2'b00};
            o_pair.first.bar_top     = bar_w;
            o_pair.first.peak_top    = uw.top;
            o_pair.first.peak_shown  = uw.shown;
            o_pair.first.last        = 1'b1;
        end
    end

endmodule

[hw/rtl/sbph_out.sv]
// spectrum bar peak hold: output register that hands out one or two draw
// beats per input beat; uses sbph_pkg
`timescale 1ns / 1ps

module sbph_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sbph_pkg::t_pair      i_pair,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sbph_pkg::t_out_beat  o_beat
);
    import sbph_pkg::*;

    logic  r_v;
    logic  r_sel;
    t_pair r_pair;
    logic  done;

    // pair is finished once its final beat is taken
    assign done    = r_v && i_ready && (r_sel || !r_pair.two);
    assign o_ready = !r_v || done;
    assign o_valid = r_v;
    assign o_beat  = r_sel ? r_pair.second : r_pair.first;

    // valid and beat select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_sel <= 1'b0;
        end else if (o_ready) begin
            r_v   <= i_valid;
            r_sel <= 1'b0;
        end else if (r_v && i_ready) begin
            r_sel <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pair <= i_pair;
        end
    end

endmodule

[hw/rtl/spectrum_bar_peak_hold_unit.sv]
// spectrum bar peak hold: top level with configuration registers, divider,
// peak memory stage and output register; uses sbph_pkg and its submodules
`timescale 1ns / 1ps
//
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------
// input     | i_valid / o_ready    | i_in_beat  (column, magnitude)
// output    | o_valid / i_ready    | o_out_beat (x, bar, peak, shown, last)
// config    | i_cfg_wr_en          | i_cfg_index, i_cfg_wdata
//
// a bin runs through the divider, peak stage and output register in turn
// wide modes take one bin per cycle unless i_ready stalls; mirrored mode
// waits for the output register to hand out the left and right beats in turn
// reset clears the valid bits of the peak memory all at once, no sweep
// a stalled output fills the divider and peak stages before o_ready drops

module spectrum_bar_peak_hold_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  sbph_pkg::t_in_beat                  i_in_beat,
    output logic                                o_valid,
    input  logic                                i_ready,
    output sbph_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_cfg_wr_en,
    input  logic [sbph_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbph_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import sbph_pkg::*;

    logic [1:0] r_style_mode;
    logic [7:0] r_scale_divisor;
    logic [3:0] r_fall_speed;
    t_cfg       cfg;

    logic       div_valid, div_ready;
    t_bar_item  div_item;
    logic       peak_valid, peak_ready;
    t_pair      peak_pair;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style_mode    <= STYLE_RESET;
            r_scale_divisor <= DIVISOR_RESET;
            r_fall_speed    <= FALL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STYLE_MODE:    r_style_mode    <= i_cfg_wdata[1:0];
                CFG_SCALE_DIVISOR: r_scale_divisor <= i_cfg_wdata;
                CFG_FALL_SPEED:    r_fall_speed    <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{style_mode: r_style_mode, scale_divisor: r_scale_divisor,
                   fall_speed: r_fall_speed};

    // bar height
    sbph_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_beat (i_in_beat),
        .i_cfg     (cfg),
        .o_valid   (div_valid),
        .i_ready   (div_ready),
        .o_item    (div_item)
    );

    // peak memory read, update, write back
    sbph_peak u_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_item  (div_item),
        .i_cfg   (cfg),
        .o_valid (peak_valid),
        .i_ready (peak_ready),
        .o_pair  (peak_pair)
    );

    // draw beats out
    sbph_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (peak_valid),
        .o_ready (peak_ready),
        .i_pair  (peak_pair),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_beat  (o_out_beat)
    );

`ifndef NO_ASSERTIONS
    // left beat taken, right beat of the same bin follows at once
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_out_beat.last |=> o_valid && o_out_beat.last)
        else $error("right beat of a mirrored pair missing");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a drawn dot never sits below the bar top
    a_dot_above_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_beat.peak_shown |-> o_out_beat.peak_top <= o_out_beat.bar_top)
        else $error("peak dot below bar top");

    // hidden dot reports row zero
    a_hidden_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_beat.peak_shown |-> o_out_beat.peak_top == '0)
        else $error("hidden peak dot with nonzero row");
`endif

endmodule

[sim/tb_top.sv]
// testbench for spectrum_bar_peak_hold_unit: sends bin beats and config writes,
// predicts the column draw beats and checks them; needs sbph_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import sbph_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED  = 30;

    // style codes that the package leaves unnamed
    localparam logic [1:0] STYLE_LOWER = 2'd3;
    localparam logic [1:0] STYLE_ZERO  = 2'd0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_beat              i_in_beat;
    logic                  o_valid;
    logic                  i_ready;
    t_out_beat             o_out_beat;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // own copy of the peak store and registers
    logic [6:0] peak_rows_seen [COLUMNS];
    logic [1:0] style_now;
    logic [7:0] divisor_now;
    logic [3:0] fall_now;
    t_out_beat  draw_beats_due [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit tx_gaps_on     = 1'b1;
    bit rx_stalls_on   = 1'b1;
    int rx_hold_req    = 0;
    logic [6:0] column_pool [8];

    spectrum_bar_peak_hold_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_beat   (i_in_beat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("spectrum_bar_peak_hold_unit regression: fail");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // one falling-dot step on a peak entry, gives one draw beat
    function automatic t_out_beat peak_fall_beat(input int idx, input int x, input int bar,
                                                 input int clampv, input int step,
                                                 input bit last);
        t_out_beat b;
        int        p;
        p         = int'(peak_rows_seen[idx]);
        b.x_pos   = 8'(x);
        b.bar_top = 6'(bar);
        b.last    = last;
        if (p > bar) begin
            p            = bar;
            b.peak_top   = '0;
            b.peak_shown = 1'b0;
        end else begin
            if (p > clampv) begin
                p = clampv;
            end
            b.peak_shown = 1'b1;
            b.peak_top   = 6'(p);
            p            = p + step;
        end
        peak_rows_seen[idx] = 7'(p);
        return b;
    endfunction

    // expected draw beats of one bin beat
    task automatic predict_draw_beats(input int col, input int mag);
        int d;
        int h;
        int bar;
        int step;
        int idx;
        d   = (divisor_now == 0) ? 1 : int'(divisor_now);
        h   = mag / d;
        if (h > int'(ROW_BOTTOM)) begin
            h = int'(ROW_BOTTOM);
        end
        bar = int'(ROW_BOTTOM) - h;
        idx = col % COLUMNS;
        if (style_now == STYLE_MIRROR) begin
            draw_beats_due.push_back(peak_fall_beat(idx, int'(X_LEFT_BASE) - col, bar,
                                                    int'(CLAMP_MIRROR), int'(FALL_MIRROR),
                                                    1'b0));
            draw_beats_due.push_back(peak_fall_beat(idx, int'(X_RIGHT_BASE) + col, bar,
                                                    int'(CLAMP_MIRROR), int'(FALL_MIRROR),
                                                    1'b1));
        end else begin
            step = (fall_now > FALL_BASE) ? 0 : int'(FALL_BASE) - int'(fall_now);
            if (style_now != STYLE_WIDE && bar < int'(ROW_MID)) begin
                bar = int'(ROW_MID);
            end
            if (bar > int'(CLAMP_WIDE)) begin
                bar = int'(CLAMP_WIDE);
            end
            draw_beats_due.push_back(peak_fall_beat(idx, col * 4, bar, int'(CLAMP_WIDE),
                                                    step, 1'b1));
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin : ready_driver
        int gap;
        int hold;
        gap = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
                i_ready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end else if (gap > 0) begin
                i_ready <= 1'b0;
                gap--;
            end else begin
                i_ready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                    gap = idle_len();
                end
            end
        end
    end

    // draw beat checker, sampled at the falling edge before acceptance
    always @(negedge i_clk) begin : beat_checker
        t_out_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (draw_beats_due.size() == 0) begin
                report_mismatch("draw beat with none pending, x_pos",
                                int'(o_out_beat.x_pos), 0);
            end else begin
                want = draw_beats_due.pop_front();
                if (o_out_beat.x_pos !== want.x_pos)
                    report_mismatch("x_pos", int'(o_out_beat.x_pos), int'(want.x_pos));
                if (o_out_beat.bar_top !== want.bar_top)
                    report_mismatch("bar_top", int'(o_out_beat.bar_top),
                                    int'(want.bar_top));
                if (o_out_beat.peak_top !== want.peak_top)
                    report_mismatch("peak_top", int'(o_out_beat.peak_top),
                                    int'(want.peak_top));
                if (o_out_beat.peak_shown !== want.peak_shown)
                    report_mismatch("peak_shown", int'(o_out_beat.peak_shown),
                                    int'(want.peak_shown));
                if (o_out_beat.last !== want.last)
                    report_mismatch("last", int'(o_out_beat.last), int'(want.last));
            end
        end
    end

    // send one bin beat; called at a rising edge, returns at the accepting edge
    task automatic send_bin(input logic [6:0] col, input logic [15:0] mag);
        int gap;
        bit took;
        gap = (tx_gaps_on && $urandom_range(0, 9) < 3) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_beat <= '{column: col, magnitude: mag};
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        predict_draw_beats(int'(col), int'(mag));
    endtask

    // stop sending and wait for every pending draw beat
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (draw_beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers, only while idle; upper data bits are noise
    task automatic set_config(input logic [1:0] mode, input logic [7:0] divisor,
                              input logic [3:0] fall);
        logic [7:0] noise_a;
        logic [7:0] noise_b;
        noise_a = 8'($urandom);
        noise_b = 8'($urandom);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_STYLE_MODE;
        i_cfg_wdata <= {noise_a[7:2], mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_SCALE_DIVISOR;
        i_cfg_wdata <= divisor;
        @(posedge i_clk);
        i_cfg_index <= CFG_FALL_SPEED;
        i_cfg_wdata <= {noise_b[7:4], fall};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        style_now   = mode;
        divisor_now = divisor;
        fall_now    = fall;
    endtask

    // magnitude that lands near a chosen bar height at the current divisor
    function automatic logic [15:0] height_to_mag(input int h);
        int d;
        int m;
        d = (divisor_now == 0) ? 1 : int'(divisor_now);
        m = h * d + $urandom_range(0, d - 1);
        if (m > 65535) begin
            m = 65535;
        end
        return 16'(m);
    endfunction

    // mostly columns of the phase pool, sometimes any column
    function automatic logic [6:0] pick_column();
        if ($urandom_range(0, 9) < 7) begin
            return column_pool[$urandom_range(0, 7)];
        end
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic test_defaults_after_reset();
        send_bin(7'd0, 16'd0);
        send_bin(7'd127, 16'hFFFF);
        send_bin(7'd1, 16'd252);
        send_bin(7'd1, 16'd3);
        send_bin(7'd1, 16'd0);
        send_bin(7'd64, 16'd100);
        wait_results_done();
    endtask

    task automatic test_wide_extremes();
        set_config(STYLE_WIDE, 8'd1, 4'd0);
        send_bin(7'd0, 16'hFFFF);
        send_bin(7'd63, 16'd0);
        send_bin(7'd63, 16'd0);
        send_bin(7'd64, 16'd40);
        send_bin(7'd127, 16'hFFFF);
        wait_results_done();
        set_config(STYLE_LOWER, 8'd255, 4'd10);
        send_bin(7'd10, 16'hFFFF);
        send_bin(7'd10, 16'd0);
        send_bin(7'd10, 16'd300);
        wait_results_done();
    endtask

    // style zero, divisor zero, fall speed above ten, mirrored column zero
    task automatic test_special_cases();
        set_config(STYLE_ZERO, 8'd0, 4'd15);
        send_bin(7'd5, 16'hFFFF);
        send_bin(7'd5, 16'd10);
        send_bin(7'd5, 16'd0);
        wait_results_done();
        set_config(STYLE_LOWER, 8'd1, 4'd11);
        send_bin(7'd70, 16'd1);
        send_bin(7'd70, 16'd1);
        wait_results_done();
        set_config(STYLE_MIRROR, 8'd255, 4'd0);
        send_bin(7'd0, 16'hFFFF);
        send_bin(7'd127, 16'd12345);
        wait_results_done();
    endtask

    task automatic test_random_phases();
        logic [1:0] mode;
        logic [7:0] divisor;
        logic [6:0] col;
        int         sent;
        int         pick;
        int         k;
        for (int ph = 0; ph < 8; ph++) begin
            mode = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 5) divisor = 8'($urandom_range(1, 8));
            else if (pick == 5) divisor = 8'd0;
            else if (pick == 6) divisor = 8'd255;
            else divisor = 8'($urandom_range(1, 255));
            set_config(mode, divisor, 4'($urandom_range(0, 15)));
            for (int i = 0; i < 8; i++) begin
                column_pool[i] = (mode == STYLE_MIRROR) ? 7'($urandom_range(1, 127))
                                                        : 7'($urandom_range(0, 63));
            end
            // one phase with no idling on either side
            tx_gaps_on   = (ph != 3);
            rx_stalls_on = (ph != 3);
            sent = 0;
            while (sent < 68) begin
                col = pick_column();
                if ($urandom_range(0, 99) < 15) begin
                    // a hit then a fading tail on one column
                    send_bin(col, height_to_mag($urandom_range(40, 63)));
                    k = $urandom_range(4, 8);
                    for (int j = 0; j < k; j++) begin
                        send_bin(col, height_to_mag($urandom_range(0, 10)));
                    end
                    sent += k + 1;
                end else if ($urandom_range(0, 9) < 2) begin
                    send_bin(col, 16'($urandom_range(0, 65535)));
                    sent++;
                end else begin
                    send_bin(col, height_to_mag($urandom_range(0, 70)));
                    sent++;
                end
            end
            wait_results_done();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_output_stall();
        set_config(STYLE_MIRROR, 8'd2, 4'd3);
        tx_gaps_on  = 1'b0;
        rx_hold_req = 400;
        for (int i = 0; i < 40; i++) begin
            send_bin(7'($urandom_range(1, 127)), 16'($urandom_range(0, 200)));
        end
        tx_gaps_on = 1'b1;
        wait_results_done();
    endtask

    // sender waits for every pending beat in the middle of a run
    task automatic test_sender_pause();
        set_config(STYLE_WIDE, 8'd3, 4'd5);
        for (int i = 0; i < 20; i++) begin
            send_bin(7'($urandom_range(0, 63)), height_to_mag($urandom_range(0, 63)));
        end
        wait_results_done();
        for (int i = 0; i < 20; i++) begin
            send_bin(7'($urandom_range(0, 63)), height_to_mag($urandom_range(0, 63)));
        end
        wait_results_done();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_in_beat   <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        for (int i = 0; i < COLUMNS; i++) begin
            peak_rows_seen[i] = PEAK_RESET;
        end
        style_now   = STYLE_RESET;
        divisor_now = DIVISOR_RESET;
        fall_now    = FALL_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_after_reset();
        test_wide_extremes();
        test_special_cases();
        test_random_phases();
        test_output_stall();
        test_sender_pause();

        if (mismatch_count == 0) begin
            $display("spectrum_bar_peak_hold_unit regression: pass");
        end else begin
            $display("spectrum_bar_peak_hold_unit regression: fail");
        end
        $finish;
    end

endmodule
